FILE: src/interval_min_max_decimator_assert.svh
// assertion macros for the interval min/max decimator
// used by the top level only; expects clk and rst_n in scope
`ifndef INTERVAL_MIN_MAX_DECIMATOR_ASSERT_SVH
`define INTERVAL_MIN_MAX_DECIMATOR_ASSERT_SVH

// property must hold at every edge out of reset
`define IVMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true out of reset
`define IVMM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/ivmm_pkg.sv
// shared constants and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
package ivmm_pkg;
  localparam int NUM_AXES = 6;
  localparam int VALUE_W  = 32;
  localparam int SLOTS    = 4;
  localparam int TIME_W   = 63;
  localparam int REV_W    = 32;
  localparam int IDX_W    = 64;
  localparam int AXIS_W   = 3;
  localparam int POS_W    = 2;

  // slot roles within one axis
  localparam logic [POS_W-1:0] SLOT_FIRST = 2'd0;
  localparam logic [POS_W-1:0] SLOT_MIN   = 2'd1;
  localparam logic [POS_W-1:0] SLOT_MAX   = 2'd2;
  localparam logic [POS_W-1:0] SLOT_LAST  = 2'd3;

  typedef struct packed {
    logic              accept;
    logic              step;
    logic              seed_hold;
    logic              busy;
    logic [AXIS_W-1:0] axis;
    logic [POS_W-1:0]  pos;
  } ivmm_cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } ivmm_sts_t;
endpackage

FILE: src/interval_min_max_decimator.sv
// top level of the interval min/max decimator
// depends on ivmm_pkg, ivmm_ctrl, ivmm_dp and the assertion macro header
//
// usage:
// - in_* carries one six-axis sample per transfer; out_* carries one point per
//   transfer; cfg_* writes interval_ns and is always ready (write while idle)
// - a sample that does not close the interval is absorbed without leaving the
//   idle state, so such samples go at one per cycle while no batch is running
// - a closing sample starts a batch: the sequencer walks 6 axes x 4 slots, one
//   slot per cycle while the output register is free, then reseeds in the seed
//   state; in_ready is low through the walk and the reseed, and any output stall
// - the first point enters the output register on the first slot step after the
//   closing transfer; skipped duplicates still take their slot step
// - batch_last marks the final point of a batch
// - when the receiver stalls, the point is held in the output register and the
//   sequencer waits; input stays blocked until the batch is done
// - reset clears the interval state, the sample counter and the output valid,
//   and sets interval_ns to 10000000; candidate slots are written by the first
//   sample before any batch reads them
`timescale 1ns / 1ps
`include "interval_min_max_decimator_assert.svh"
module interval_min_max_decimator
  import ivmm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TIME_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TIME_W-1:0]         in_mono_time,
  input  logic [TIME_W-1:0]         in_host_time,
  input  logic [REV_W-1:0]          in_revision,
  input  logic signed [VALUE_W-1:0] in_force_x,
  input  logic signed [VALUE_W-1:0] in_force_y,
  input  logic signed [VALUE_W-1:0] in_force_z,
  input  logic signed [VALUE_W-1:0] in_torque_x,
  input  logic signed [VALUE_W-1:0] in_torque_y,
  input  logic signed [VALUE_W-1:0] in_torque_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AXIS_W-1:0]         out_axis_id,
  output logic [TIME_W-1:0]         out_point_time,
  output logic signed [VALUE_W-1:0] out_point_value,
  output logic                      out_batch_last
);
  ivmm_cmd_t                 cmd;
  ivmm_sts_t                 sts;
  logic signed [VALUE_W-1:0] vals [NUM_AXES];

  assign cfg_ready = 1'b1;
  assign vals[0] = in_force_x;
  assign vals[1] = in_force_y;
  assign vals[2] = in_force_z;
  assign vals[3] = in_torque_x;
  assign vals[4] = in_torque_y;
  assign vals[5] = in_torque_z;

  ivmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ivmm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_mono_time    (in_mono_time),
    .in_host_time    (in_host_time),
    .in_revision     (in_revision),
    .in_val          (vals),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_axis_id     (out_axis_id),
    .out_point_time  (out_point_time),
    .out_point_value (out_point_value),
    .out_batch_last  (out_batch_last)
  );

  `IVMM_NEVER(a_no_accept_busy, in_ready && cmd.busy, "input ready during batch")
  `IVMM_ASSERT(a_step_room, cmd.step |-> (!out_valid || out_ready), "step with output full")
  `IVMM_ASSERT(a_seed_after_walk, (cmd.step && cmd.pos == SLOT_LAST && cmd.axis == AXIS_W'(NUM_AXES - 1)) |=> cmd.seed_hold, "no reseed after batch")
endmodule

FILE: src/ivmm_ctrl.sv
// controller: accept, batch emission sequencing and reseed
// depends on ivmm_pkg
`timescale 1ns / 1ps
module ivmm_ctrl
  import ivmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ivmm_sts_t sts,
  output ivmm_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_SEED = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              last_pos;

  assign in_ready      = (state_r == S_IDLE);
  assign cmd.accept    = in_valid && (state_r == S_IDLE);
  assign cmd.step      = (state_r == S_EMIT) && sts.out_free;
  assign cmd.seed_hold = (state_r == S_SEED);
  assign cmd.busy      = (state_r != S_IDLE);
  assign cmd.axis      = axis_r;
  assign cmd.pos       = pos_r;
  assign last_pos      = (axis_r == AXIS_W'(NUM_AXES - 1)) && (pos_r == SLOT_LAST);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.close) begin
          state_nxt = S_EMIT;
          axis_nxt  = '0;
          pos_nxt   = '0;
        end
      end
      S_EMIT: begin
        if (cmd.step) begin
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r == SLOT_LAST) begin
            axis_nxt = axis_r + AXIS_W'(1);
          end
          if (last_pos) begin
            state_nxt = S_SEED;
          end
        end
      end
      S_SEED: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      pos_r   <= pos_nxt;
    end
  end
endmodule

FILE: src/ivmm_dp.sv
// datapath: interval state, per-axis candidate slots, point selection, output register
// depends on ivmm_pkg
`timescale 1ns / 1ps
module ivmm_dp
  import ivmm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [TIME_W-1:0]         cfg_data,
  input  logic [TIME_W-1:0]         in_mono_time,
  input  logic [TIME_W-1:0]         in_host_time,
  input  logic [REV_W-1:0]          in_revision,
  input  logic signed [VALUE_W-1:0] in_val [NUM_AXES],
  input  ivmm_cmd_t                 cmd,
  output ivmm_sts_t                 sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AXIS_W-1:0]         out_axis_id,
  output logic [TIME_W-1:0]         out_point_time,
  output logic signed [VALUE_W-1:0] out_point_value,
  output logic                      out_batch_last
);
  logic [TIME_W-1:0] interval_r;
  logic              open_r;
  logic [TIME_W-1:0] start_r, latest_r;
  logic [REV_W-1:0]  rev_r;
  logic [IDX_W-1:0]  cnt_r;

  logic [TIME_W-1:0]         host_r [NUM_AXES][SLOTS];
  logic signed [VALUE_W-1:0] val_r  [NUM_AXES][SLOTS];
  logic [IDX_W-1:0]          idx_r  [NUM_AXES][SLOTS];

  logic [TIME_W-1:0]         hold_host_r, hold_mono_r;
  logic signed [VALUE_W-1:0] hold_val_r [NUM_AXES];

  logic                      out_valid_r;
  logic [AXIS_W-1:0]         out_axis_r;
  logic [TIME_W-1:0]         out_time_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_last_r;

  logic             rev_chg, backwards, due;
  logic             do_seed, do_accum;
  logic [IDX_W-1:0] seed_idx;
  logic [POS_W-1:0] lo_slot, hi_slot, sel, prev;
  logic             emit_ok, rotate;

  assign rev_chg   = (in_revision != rev_r);
  assign backwards = (in_mono_time < latest_r);
  assign due       = ((in_mono_time - start_r) >= interval_r);
  assign sts.close = open_r && !rev_chg && !backwards && due;
  assign sts.out_free = !out_valid_r || out_ready;

  assign do_seed  = cmd.accept && (!open_r || rev_chg);
  assign do_accum = cmd.accept && open_r && !rev_chg && !backwards && !due;
  assign seed_idx = (open_r && rev_chg) ? '0 : cnt_r;

  // within an interval sample order equals index order, so sort by index
  always_comb begin
    if (idx_r[0][SLOT_MIN] < idx_r[0][SLOT_MAX]) begin
      lo_slot = SLOT_MIN;
      hi_slot = SLOT_MAX;
    end else begin
      lo_slot = SLOT_MAX;
      hi_slot = SLOT_MIN;
    end
    case (cmd.pos)
      2'd0:    begin sel = SLOT_FIRST; prev = SLOT_FIRST; end
      2'd1:    begin sel = lo_slot;    prev = SLOT_FIRST; end
      2'd2:    begin sel = hi_slot;    prev = lo_slot;    end
      default: begin sel = SLOT_LAST;  prev = hi_slot;    end
    endcase
  end

  assign emit_ok = (cmd.pos == SLOT_FIRST) || (idx_r[0][sel] != idx_r[0][prev]);
  assign rotate  = cmd.step && (cmd.pos == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= TIME_W'(10000000);
      open_r      <= 1'b0;
      start_r     <= '0;
      latest_r    <= '0;
      rev_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        interval_r <= cfg_data;
      end
      if (do_seed) begin
        open_r   <= 1'b1;
        start_r  <= in_mono_time;
        latest_r <= in_mono_time;
        rev_r    <= in_revision;
        cnt_r    <= seed_idx + IDX_W'(1);
      end else if (do_accum) begin
        latest_r <= in_mono_time;
        cnt_r    <= cnt_r + IDX_W'(1);
      end else if (cmd.seed_hold) begin
        start_r  <= hold_mono_r;
        latest_r <= hold_mono_r;
        cnt_r    <= cnt_r + IDX_W'(1);
      end
      if (cmd.step && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_host_r <= in_host_time;
      hold_mono_r <= in_mono_time;
      hold_val_r  <= in_val;
    end
    if (cmd.step && emit_ok) begin
      out_axis_r  <= cmd.axis;
      out_time_r  <= host_r[0][sel];
      out_value_r <= val_r[0][sel];
      out_last_r  <= (cmd.axis == AXIS_W'(NUM_AXES - 1)) &&
                     (idx_r[0][sel] == idx_r[0][SLOT_LAST]);
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      if (do_seed) begin
        for (int k = 0; k < SLOTS; k++) begin
          host_r[a][k] <= in_host_time;
          val_r[a][k]  <= in_val[a];
          idx_r[a][k]  <= seed_idx;
        end
      end else if (cmd.seed_hold) begin
        for (int k = 0; k < SLOTS; k++) begin
          host_r[a][k] <= hold_host_r;
          val_r[a][k]  <= hold_val_r[a];
          idx_r[a][k]  <= cnt_r;
        end
      end else if (do_accum) begin
        if (in_val[a] < val_r[a][SLOT_MIN]) begin
          host_r[a][SLOT_MIN] <= in_host_time;
          val_r[a][SLOT_MIN]  <= in_val[a];
          idx_r[a][SLOT_MIN]  <= cnt_r;
        end
        if (in_val[a] > val_r[a][SLOT_MAX]) begin
          host_r[a][SLOT_MAX] <= in_host_time;
          val_r[a][SLOT_MAX]  <= in_val[a];
          idx_r[a][SLOT_MAX]  <= cnt_r;
        end
        host_r[a][SLOT_LAST] <= in_host_time;
        val_r[a][SLOT_LAST]  <= in_val[a];
        idx_r[a][SLOT_LAST]  <= cnt_r;
      end else if (rotate) begin
        // bring the next axis to the read position
        host_r[a] <= host_r[(a + 1) % NUM_AXES];
        val_r[a]  <= val_r[(a + 1) % NUM_AXES];
        idx_r[a]  <= idx_r[(a + 1) % NUM_AXES];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_axis_id     = out_axis_r;
  assign out_point_time  = out_time_r;
  assign out_point_value = out_value_r;
  assign out_batch_last  = out_last_r;
endmodule

FILE: test/tb.sv
// self-checking testbench for interval_min_max_decimator
// depends on ivmm_pkg and the decimator RTL; a directed table, then random samples
`timescale 1ns / 1ps
module tb;
  import ivmm_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [TIME_W-1:0]  ptime;
    logic [VALUE_W-1:0] value;
    logic               last;
  } point_t;

  typedef struct packed {
    logic                              is_cfg;
    logic [TIME_W-1:0]                 mono;
    logic [TIME_W-1:0]                 host;
    logic [REV_W-1:0]                  rev;
    logic [NUM_AXES-1:0][VALUE_W-1:0]  vals;
    int                                npts;   // -1: predictor only
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [TIME_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic [TIME_W-1:0] in_mono_time = '0, in_host_time = '0;
  logic [REV_W-1:0] in_revision = '0;
  logic signed [VALUE_W-1:0] in_force_x = '0, in_force_y = '0, in_force_z = '0;
  logic signed [VALUE_W-1:0] in_torque_x = '0, in_torque_y = '0, in_torque_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic [AXIS_W-1:0] out_axis_id;
  logic [TIME_W-1:0] out_point_time;
  logic signed [VALUE_W-1:0] out_point_value;
  logic out_batch_last;

  interval_min_max_decimator i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // predictor state
  logic [TIME_W-1:0]  interval_len;
  logic               seg_open;
  logic [TIME_W-1:0]  seg_start, seg_latest;
  logic [REV_W-1:0]   seg_rev;
  logic [IDX_W-1:0]   sample_idx;
  logic [TIME_W-1:0]  kept_host [NUM_AXES][SLOTS];
  logic [TIME_W-1:0]  kept_mono [NUM_AXES][SLOTS];
  logic signed [VALUE_W-1:0] kept_val [NUM_AXES][SLOTS];
  logic [IDX_W-1:0]   kept_idx [NUM_AXES][SLOTS];

  point_t pending_points[$];
  int in_idle_pct = 0, out_idle_pct = 0;
  int mismatches = 0, samples_sent = 0, points_seen = 0, batches_seen = 0;
  logic [TIME_W-1:0] gen_mono = '0;
  logic [REV_W-1:0]  gen_rev = '0;

  function automatic void keep_slot(int a, int s, row_t r);
    kept_host[a][s] = r.host;
    kept_mono[a][s] = r.mono;
    kept_val[a][s]  = r.vals[a];
    kept_idx[a][s]  = sample_idx;
  endfunction

  function automatic void open_segment(row_t r);
    seg_open = 1'b1;
    seg_start = r.mono;
    seg_latest = r.mono;
    seg_rev = r.rev;
    for (int a = 0; a < NUM_AXES; a++)
      for (int s = 0; s < SLOTS; s++) keep_slot(a, s, r);
    sample_idx++;
  endfunction

  function automatic bit slot_earlier(int a, int x, int y);
    if (kept_mono[a][x] != kept_mono[a][y]) return kept_mono[a][x] < kept_mono[a][y];
    return kept_idx[a][x] < kept_idx[a][y];
  endfunction

  // returns the number of points the sample closes out
  function automatic int predict_points(row_t r);
    int n, ord[SLOTS], cur, j, nseen;
    logic [IDX_W-1:0] seen[SLOTS];
    bit dup;
    point_t p;
    n = 0;
    if (!seg_open) begin
      open_segment(r);
      return 0;
    end
    if (r.rev != seg_rev) begin
      sample_idx = '0;
      open_segment(r);
      return 0;
    end
    if (r.mono < seg_latest) return 0;
    if (r.mono - seg_start >= interval_len) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int i = 0; i < SLOTS; i++) ord[i] = i;
        for (int i = 1; i < SLOTS; i++) begin
          cur = ord[i];
          j = i;
          while (j > 0 && slot_earlier(a, cur, ord[j-1])) begin
            ord[j] = ord[j-1];
            j--;
          end
          ord[j] = cur;
        end
        nseen = 0;
        for (int i = 0; i < SLOTS; i++) begin
          dup = 1'b0;
          for (int k = 0; k < nseen; k++)
            if (seen[k] == kept_idx[a][ord[i]]) dup = 1'b1;
          if (!dup) begin
            seen[nseen++] = kept_idx[a][ord[i]];
            p.axis = AXIS_W'(a);
            p.ptime = kept_host[a][ord[i]];
            p.value = kept_val[a][ord[i]];
            p.last = 1'b0;
            pending_points.push_back(p);
            n++;
          end
        end
      end
      if (n > 0) pending_points[$].last = 1'b1;
      open_segment(r);
      return n;
    end
    seg_latest = r.mono;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (kept_val[a][SLOT_MIN] > $signed(r.vals[a])) keep_slot(a, SLOT_MIN, r);
      if (kept_val[a][SLOT_MAX] < $signed(r.vals[a])) keep_slot(a, SLOT_MAX, r);
      keep_slot(a, SLOT_LAST, r);
    end
    sample_idx++;
    return 0;
  endfunction

  task automatic write_interval(logic [TIME_W-1:0] len);
    // the last sample transfer is done, take valid down before waiting
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_points.size() == 0);
    // a batch may still be reseeding after its last point
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    interval_len = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(row_t r);
    int n;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mono_time = r.mono;
    in_host_time = r.host;
    in_revision = r.rev;
    {in_torque_z, in_torque_y, in_torque_x, in_force_z, in_force_y, in_force_x} = r.vals;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    n = predict_points(r);
    if (n > 0) batches_seen++;
    if (r.npts >= 0 && n != r.npts) begin
      mismatches++;
      if (mismatches <= 10)
        $display("sample %0d: expected %0d points, predicted %0d", samples_sent, r.npts, n);
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(logic [VALUE_W-1:0] prev);
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return prev;
      4, 5: return VALUE_W'($signed($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t random_sample();
    row_t r;
    logic [TIME_W:0] next, step;
    int pick;
    r.is_cfg = 1'b0;
    r.npts = -1;
    r.host = TIME_W'({$urandom, $urandom});
    for (int a = 0; a < NUM_AXES; a++) r.vals[a] = pick_value(in_force_x);
    r.vals[1] = pick_value(r.vals[0]);
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: step = '0;
      1: step = interval_len >> $urandom_range(1, 6);
      2: step = interval_len;
      default: step = interval_len + $urandom_range(40);
    endcase
    next = gen_mono + step;
    if (pick < 6 || next[TIME_W]) begin
      gen_rev = ($urandom_range(1)) ? gen_rev + 1 : $urandom;
      gen_mono = TIME_W'({$urandom, $urandom} >> $urandom_range(0, 24));
      if (gen_mono[TIME_W-1]) gen_mono = gen_mono ^ {2'b01, {(TIME_W-2){1'b0}}};
    end else if (pick < 12 && gen_mono != 0) begin
      r.mono = gen_mono - 1 - $urandom_range(0, 1000) % gen_mono;
      r.rev = gen_rev;
      return r;
    end else begin
      gen_mono = next[TIME_W-1:0];
    end
    r.mono = gen_mono;
    r.rev = gen_rev;
    return r;
  endfunction

  task automatic run_random(logic [TIME_W-1:0] len, int count);
    write_interval(len);
    for (int i = 0; i < count; i++) send_sample(random_sample());
  endtask

  // checking
  always @(posedge clk) begin
    point_t exp_p;
    if (rst_n && out_valid && out_ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point axis %0d", out_axis_id);
      end else begin
        exp_p = pending_points.pop_front();
        if (exp_p.axis != out_axis_id || exp_p.ptime != out_point_time ||
            exp_p.value != out_point_value || exp_p.last != out_batch_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp axis %0d time %0d value %0d last %0b, got %0d %0d %0d %0b",
                     exp_p.axis, exp_p.ptime, $signed(exp_p.value), exp_p.last,
                     out_axis_id, out_point_time, out_point_value, out_batch_last);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  function automatic row_t mk(logic [TIME_W-1:0] mono, logic [TIME_W-1:0] host,
                              logic [REV_W-1:0] rev, logic [VALUE_W-1:0] v, int npts);
    row_t r;
    r.is_cfg = 1'b0;
    r.mono = mono;
    r.host = host;
    r.rev = rev;
    for (int a = 0; a < NUM_AXES; a++) r.vals[a] = v;
    r.npts = npts;
    return r;
  endfunction

  function automatic row_t mk_cfg(logic [TIME_W-1:0] len);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.mono = len;
    return r;
  endfunction

  initial begin
    row_t plan[$];
    row_t r;
    interval_len = TIME_W'(10000000);
    seg_open = 1'b0;
    seg_start = '0;
    seg_latest = '0;
    seg_rev = '0;
    sample_idx = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first sample seeds, extremes, tie on min, backwards time, closing sample
    plan.push_back(mk(0, 0, 0, '0, 0));
    plan.push_back(mk(100, TIME_MAX, 0, VAL_MAX, 0));
    plan.push_back(mk(200, 7, 0, VAL_MIN, 0));
    plan.push_back(mk(200, 8, 0, VAL_MIN, 0));
    plan.push_back(mk(50, 9, 0, VAL_MAX, 0));
    plan.push_back(mk(10000000, 10, 0, 32'd5, 24));
    // revision change drops the open interval
    plan.push_back(mk(20000000, 11, 5, 32'd3, 0));
    r = mk(20000001, 12, 5, 32'd3, -1);
    r.vals[2] = VAL_MIN;
    r.vals[4] = VAL_MAX;
    plan.push_back(r);
    plan.push_back(mk(30000000, 13, 5, 32'hdead_beef, -1));
    plan.push_back(mk(TIME_MAX, TIME_MAX, {REV_W{1'b1}}, VAL_MIN, 0));
    plan.push_back(mk_cfg(TIME_MAX));
    plan.push_back(mk(0, 1, 1, 32'd1, 0));
    plan.push_back(mk(TIME_MAX, 2, 1, 32'd2, 6));
    plan.push_back(mk_cfg('0));
    plan.push_back(mk(TIME_MAX, 3, 1, 32'd3, 6));
    plan.push_back(mk(TIME_MAX, 4, 1, 32'd4, 6));
    plan.push_back(mk_cfg(TIME_W'(1)));
    plan.push_back(mk(TIME_MAX, 5, 2, 32'd5, 0));

    in_idle_pct = 34;
    out_idle_pct = 78;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_interval(plan[i].mono);
      else send_sample(plan[i]);
    end
    gen_mono = TIME_MAX;
    gen_rev = 2;

    run_random(TIME_W'(1000), 110);
    in_idle_pct = 78;
    out_idle_pct = 34;
    run_random('0, 60);
    run_random(TIME_W'(10000000), 50);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_random(TIME_MAX, 20);
    run_random(TIME_W'(3), 90);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_points.size() == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d samples across several interval lengths; %0d batches, %0d points checked",
             samples_sent, batches_seen, points_seen);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/ivmm_pkg.sv
src/ivmm_ctrl.sv
src/ivmm_dp.sv
src/interval_min_max_decimator.sv
test/tb.sv
